// ----- rtl/core/y2p_pkg.sv -----
// y2p_pkg: shared widths, register indexes, sequencer states and helper
// functions for the YV12 to packed YUV 4:4:4 converter.
// No dependencies; every other file in rtl/core imports it.
package y2p_pkg;

  // Field and datapath widths
  localparam int BYTE_W     = 8;
  localparam int DIM_W      = 10;
  localparam int STRIDE_W   = 13;
  localparam int ADDR_W     = 21;
  localparam int SIZE_W     = 2 * DIM_W;      // luma plane size, width * height
  localparam int POS_W      = SIZE_W + 1;     // whole frame, 1.5 * luma size
  localparam int HALF_W     = DIM_W - 1;      // block column / block row
  localparam int QUO_W      = SIZE_W - 2;     // index into the U plane
  localparam int ACC_W      = 24;             // multiply-add result
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = STRIDE_W;

  // Default store limits
  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;

  // Register reset values
  localparam logic [DIM_W-1:0]    RST_FRAME_WIDTH  = DIM_W'(512);
  localparam logic [DIM_W-1:0]    RST_FRAME_HEIGHT = DIM_W'(512);
  localparam logic [STRIDE_W-1:0] RST_ROW_STRIDE   = STRIDE_W'(1536);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE   = CFG_IDX_W'(2);

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIZE,
    ST_SIZE_WB,
    ST_CLASS,
    ST_DIV,
    ST_LIDX,
    ST_ADDR,
    ST_EMIT
  } seq_state_t;

  // Clamp a frame dimension to 2..maxv and force it even
  function automatic logic [DIM_W-1:0] clamp_even(input logic [DIM_W-1:0] v,
                                                  input int maxv);
    int vi;
    vi = int'(v);
    if (vi < 2) vi = 2;
    if (vi > maxv) vi = maxv;
    return DIM_W'(vi & ~1);
  endfunction

endpackage

// ----- rtl/core/y2p_store.sv -----
// y2p_store: luma plane and V plane storage, one write and one registered
// read port per plane. Depends on y2p_pkg for the byte width.
module y2p_store #(
  parameter int LUMA_DEPTH   = 4,
  parameter int CHROMA_DEPTH = 1,
  parameter int LUMA_AW      = 2,
  parameter int CHROMA_AW    = 1
) (
  input  logic                       clk,
  input  logic                       luma_we,
  input  logic [LUMA_AW-1:0]         luma_waddr,
  input  logic [y2p_pkg::BYTE_W-1:0] luma_wdata,
  input  logic                       luma_re,
  input  logic [LUMA_AW-1:0]         luma_raddr,
  output logic [y2p_pkg::BYTE_W-1:0] luma_rdata,
  input  logic                       v_we,
  input  logic [CHROMA_AW-1:0]       v_waddr,
  input  logic [y2p_pkg::BYTE_W-1:0] v_wdata,
  input  logic                       v_re,
  input  logic [CHROMA_AW-1:0]       v_raddr,
  output logic [y2p_pkg::BYTE_W-1:0] v_rdata
);
  import y2p_pkg::*;

  logic [BYTE_W-1:0] luma_mem [LUMA_DEPTH];
  logic [BYTE_W-1:0] v_mem    [CHROMA_DEPTH];
  logic [BYTE_W-1:0] luma_rd_r;
  logic [BYTE_W-1:0] v_rd_r;

  // Luma plane: write a Y byte, read one pixel per cycle during emission
  always_ff @(posedge clk) begin
    if (luma_we) begin
      luma_mem[luma_waddr] <= luma_wdata;
    end
    if (luma_re) begin
      luma_rd_r <= luma_mem[luma_raddr];
    end
  end

  // V plane: write a V byte, read once per 2x2 block and hold
  always_ff @(posedge clk) begin
    if (v_we) begin
      v_mem[v_waddr] <= v_wdata;
    end
    if (v_re) begin
      v_rd_r <= v_mem[v_raddr];
    end
  end

  assign luma_rdata = luma_rd_r;
  assign v_rdata    = v_rd_r;

endmodule

// ----- rtl/core/y2p_mac.sv -----
// y2p_mac: shared multiply-add unit, p = a * b + c, result registered.
// Used for the plane size, the luma index and the output address.
// Depends on y2p_pkg for operand widths.
module y2p_mac (
  input  logic                         clk,
  input  logic                         en,
  input  logic [y2p_pkg::DIM_W-1:0]    a,
  input  logic [y2p_pkg::STRIDE_W-1:0] b,
  input  logic [y2p_pkg::ACC_W-1:0]    c,
  output logic [y2p_pkg::ACC_W-1:0]    p
);
  import y2p_pkg::*;

  logic [ACC_W-1:0] p_r;
  logic [ACC_W-1:0] p_nxt;

  // Multiply at full width, then add the offset
  assign p_nxt = ACC_W'(a) * ACC_W'(b) + c;

  // Hold the product until the next operation
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

// ----- rtl/core/y2p_divider.sv -----
// y2p_divider: restoring divider, one quotient bit per cycle, splits a
// U plane index into block row and block column. Depends on y2p_pkg.
module y2p_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [y2p_pkg::QUO_W-1:0]  dividend,
  input  logic [y2p_pkg::HALF_W-1:0] divisor,
  output logic                       done,
  output logic [y2p_pkg::HALF_W-1:0] quotient,
  output logic [y2p_pkg::HALF_W-1:0] remainder
);
  import y2p_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [HALF_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [HALF_W:0]   trial;
  logic              fits;

  // Shift in the next dividend bit and try a subtract
  assign trial = {rem_r, quo_r[QUO_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      cnt_nxt = CNT_W'(QUO_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = fits ? HALF_W'(trial - {1'b0, divisor}) : HALF_W'(trial);
      quo_nxt = {quo_r[QUO_W-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r[HALF_W-1:0];
  assign remainder = rem_r;

endmodule

// ----- rtl/core/yv12_to_packed_yuv444.sv -----
// yv12_to_packed_yuv444: top level, register file, sequencer and address math.
// Depends on y2p_pkg, y2p_store, y2p_mac and y2p_divider.
//
// Feed the YV12 frame one byte per transaction (Y plane, then V, then U);
// start is taken whenever busy is low. A Y or V byte is stored. A U byte
// completes a 2x2 block: it is classified, makes two passes through the
// shared multiply-add unit (luma index, then output address), and gives
// four pixels on out_valid in consecutive cycles, top-left, top-right,
// bottom-left, bottom-right. The receiver cannot stall: every out_valid
// cycle carries a pixel that is gone on the next edge. After any register
// write the first byte first recomputes the plane size, and if that byte
// is a U byte past the first of the U plane, the divider then finds its
// block position. Registers must be written only while the block is idle;
// the block itself does not enforce this, and cfg_ready is always high.
// Odd or out-of-range sizes are clamped to 2..MAX and forced even.
module yv12_to_packed_yuv444 #(
  parameter int MAX_WIDTH  = y2p_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = y2p_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [y2p_pkg::BYTE_W-1:0]     in_frame_byte,
  output logic                           out_valid,
  output logic [y2p_pkg::BYTE_W-1:0]     out_luma,
  output logic [y2p_pkg::BYTE_W-1:0]     out_chroma_u,
  output logic [y2p_pkg::BYTE_W-1:0]     out_chroma_v,
  output logic [y2p_pkg::ADDR_W-1:0]     out_address,
  output logic                           out_last_of_run,
  output logic                           out_last_of_frame,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [y2p_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [y2p_pkg::CFG_DATA_W-1:0] cfg_data
);
  import y2p_pkg::*;

  localparam int LUMA_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int CHROMA_DEPTH = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);
  localparam int LUMA_AW      = (LUMA_DEPTH > 1) ? $clog2(LUMA_DEPTH) : 1;
  localparam int CHROMA_AW    = (CHROMA_DEPTH > 1) ? $clog2(CHROMA_DEPTH) : 1;

  // Configuration registers
  logic [DIM_W-1:0]    frame_width_r;
  logic [DIM_W-1:0]    frame_height_r;
  logic [STRIDE_W-1:0] row_stride_r;
  logic                cfg_accept;

  // Sequencer and datapath state
  seq_state_t        state_r, state_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              size_ok_r, size_ok_nxt;
  logic              sync_r, sync_nxt;
  logic [1:0]        k_r, k_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic [SIZE_W-1:0] ysize_r, ysize_nxt;
  logic [POS_W-1:0]  vend_r, vend_nxt;
  logic [POS_W-1:0]  total_r, total_nxt;
  logic [HALF_W-1:0] bc_r, bc_nxt;
  logic [HALF_W-1:0] br_r, br_nxt;
  logic [SIZE_W-1:0] li_base_r, li_base_nxt;
  logic              lastf_r, lastf_nxt;

  // Effective sizes and derived positions
  logic [DIM_W-1:0]  w_eff;
  logic [DIM_W-1:0]  h_eff;
  logic [HALF_W-1:0] half_w;
  logic [DIM_W-1:0]  row0;
  logic [DIM_W-1:0]  col0;
  logic [POS_W-1:0]  pos_w;
  logic [POS_W-1:0]  pos_inc;
  logic [POS_W-1:0]  t_full;
  logic [SIZE_W-1:0] li_off;
  logic [ADDR_W-1:0] addr_off;

  // Shared unit and store hookup
  logic                 mac_en;
  logic [DIM_W-1:0]     mac_a;
  logic [STRIDE_W-1:0]  mac_b;
  logic [ACC_W-1:0]     mac_c;
  logic [ACC_W-1:0]     mac_p;
  logic                 luma_we, luma_re, v_we, v_re;
  logic [LUMA_AW-1:0]   luma_waddr, luma_raddr;
  logic [CHROMA_AW-1:0] v_waddr, v_raddr;
  logic [BYTE_W-1:0]    luma_rdata, v_rdata;
  logic                 div_start, div_done;
  logic [HALF_W-1:0]    div_quo, div_rem;

  assign cfg_ready  = 1'b1;
  assign cfg_accept = cfg_valid & cfg_ready;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
      row_stride_r   <= RST_ROW_STRIDE;
    end else if (cfg_accept) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[DIM_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[DIM_W-1:0];
        CFG_ROW_STRIDE:   row_stride_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_eff  = clamp_even(frame_width_r, MAX_WIDTH);
  assign h_eff  = clamp_even(frame_height_r, MAX_HEIGHT);
  assign half_w = w_eff[DIM_W-1:1];
  assign row0   = {br_r, 1'b0};
  assign col0   = {bc_r, 1'b0};

  // Restart the frame if a size change left the position past its end
  assign pos_w   = (pos_r >= total_r) ? '0 : pos_r;
  assign pos_inc = pos_w + POS_W'(1);
  assign t_full  = pos_w - vend_r;

  // Offsets of the next pixel's luma index and this pixel's address
  always_comb begin
    case (k_r)
      2'd0:    li_off = SIZE_W'(1);
      2'd1:    li_off = SIZE_W'(w_eff);
      default: li_off = SIZE_W'(w_eff) + SIZE_W'(1);
    endcase
    case (k_r)
      2'd0:    addr_off = '0;
      2'd1:    addr_off = ADDR_W'(3);
      2'd2:    addr_off = ADDR_W'(row_stride_r);
      default: addr_off = ADDR_W'(row_stride_r) + ADDR_W'(3);
    endcase
  end

  // Sequencer: next state and datapath controls
  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    size_ok_nxt = size_ok_r;
    sync_nxt    = sync_r;
    k_nxt       = k_r;
    byte_nxt    = byte_r;
    ysize_nxt   = ysize_r;
    vend_nxt    = vend_r;
    total_nxt   = total_r;
    bc_nxt      = bc_r;
    br_nxt      = br_r;
    li_base_nxt = li_base_r;
    lastf_nxt   = lastf_r;
    mac_en      = 1'b0;
    mac_a       = '0;
    mac_b       = '0;
    mac_c       = '0;
    luma_we     = 1'b0;
    luma_re     = 1'b0;
    luma_waddr  = LUMA_AW'(pos_w);
    luma_raddr  = LUMA_AW'(li_base_r + li_off);
    v_we        = 1'b0;
    v_re        = 1'b0;
    v_waddr     = CHROMA_AW'(pos_w - POS_W'(ysize_r));
    v_raddr     = CHROMA_AW'(t_full);
    div_start   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          byte_nxt  = in_frame_byte;
          state_nxt = size_ok_r ? ST_CLASS : ST_SIZE;
        end
      end
      ST_SIZE: begin
        mac_en    = 1'b1;
        mac_a     = w_eff;
        mac_b     = STRIDE_W'(h_eff);
        state_nxt = ST_SIZE_WB;
      end
      ST_SIZE_WB: begin
        ysize_nxt   = mac_p[SIZE_W-1:0];
        vend_nxt    = POS_W'(mac_p[SIZE_W-1:0]) + POS_W'(mac_p[SIZE_W-1:2]);
        total_nxt   = POS_W'(mac_p[SIZE_W-1:0]) + POS_W'(mac_p[SIZE_W-1:1]);
        size_ok_nxt = 1'b1;
        state_nxt   = ST_CLASS;
      end
      ST_CLASS: begin
        if (pos_w < POS_W'(ysize_r)) begin
          // Y byte: store it
          luma_we   = 1'b1;
          pos_nxt   = pos_inc;
          state_nxt = ST_IDLE;
        end else if (pos_w < vend_r) begin
          // V byte: store it
          v_we      = 1'b1;
          pos_nxt   = pos_inc;
          state_nxt = ST_IDLE;
        end else begin
          // U byte: fetch V, locate the block
          v_re      = 1'b1;
          lastf_nxt = (pos_inc == total_r);
          pos_nxt   = (pos_inc == total_r) ? '0 : pos_inc;
          if (t_full == '0) begin
            bc_nxt    = '0;
            br_nxt    = '0;
            state_nxt = ST_LIDX;
          end else if (sync_r) begin
            state_nxt = ST_LIDX;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          bc_nxt    = div_rem;
          br_nxt    = div_quo;
          state_nxt = ST_LIDX;
        end
      end
      ST_LIDX: begin
        mac_en    = 1'b1;
        mac_a     = row0;
        mac_b     = STRIDE_W'(w_eff);
        mac_c     = ACC_W'(col0);
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        // Read the top-left Y while the address base is formed
        li_base_nxt = mac_p[SIZE_W-1:0];
        luma_re     = 1'b1;
        luma_raddr  = LUMA_AW'(mac_p[SIZE_W-1:0]);
        mac_en      = 1'b1;
        mac_a       = row0;
        mac_b       = row_stride_r;
        mac_c       = ACC_W'(col0) + ACC_W'({col0, 1'b0});
        k_nxt       = 2'd0;
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        if (k_r != 2'd3) begin
          luma_re = 1'b1;
          k_nxt   = k_r + 2'd1;
        end else begin
          // Advance to the next block of the U plane
          sync_nxt = 1'b1;
          if (bc_r + HALF_W'(1) == half_w) begin
            bc_nxt = '0;
            br_nxt = br_r + HALF_W'(1);
          end else begin
            bc_nxt = bc_r + HALF_W'(1);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // Any register write invalidates cached sizes and block position
    if (cfg_accept) begin
      size_ok_nxt = 1'b0;
      sync_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      size_ok_r <= 1'b0;
      sync_r    <= 1'b0;
      k_r       <= '0;
    end else begin
      pos_r     <= pos_nxt;
      size_ok_r <= size_ok_nxt;
      sync_r    <= sync_nxt;
      k_r       <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r    <= byte_nxt;
    ysize_r   <= ysize_nxt;
    vend_r    <= vend_nxt;
    total_r   <= total_nxt;
    bc_r      <= bc_nxt;
    br_r      <= br_nxt;
    li_base_r <= li_base_nxt;
    lastf_r   <= lastf_nxt;
  end

  y2p_mac u_mac (
    .clk (clk),
    .en  (mac_en),
    .a   (mac_a),
    .b   (mac_b),
    .c   (mac_c),
    .p   (mac_p)
  );

  y2p_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (QUO_W'(t_full)),
    .divisor   (half_w),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  y2p_store #(
    .LUMA_DEPTH   (LUMA_DEPTH),
    .CHROMA_DEPTH (CHROMA_DEPTH),
    .LUMA_AW      (LUMA_AW),
    .CHROMA_AW    (CHROMA_AW)
  ) u_store (
    .clk        (clk),
    .luma_we    (luma_we),
    .luma_waddr (luma_waddr),
    .luma_wdata (byte_r),
    .luma_re    (luma_re),
    .luma_raddr (luma_raddr),
    .luma_rdata (luma_rdata),
    .v_we       (v_we),
    .v_waddr    (v_waddr),
    .v_wdata    (byte_r),
    .v_re       (v_re),
    .v_raddr    (v_raddr),
    .v_rdata    (v_rdata)
  );

  // Result transaction, one pixel per emit cycle
  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = (state_r == ST_EMIT);
  assign out_luma          = luma_rdata;
  assign out_chroma_u      = byte_r;
  assign out_chroma_v      = v_rdata;
  assign out_address       = mac_p[ADDR_W-1:0] + addr_off;
  assign out_last_of_run   = (k_r == 2'd3);
  assign out_last_of_frame = (k_r == 2'd3) & lastf_r;

endmodule
